// ----- rtl/wifi_module_serial_responder_macros.svh -----
// Assertion macros for the serial responder RTL.
`ifndef WIFI_MODULE_SERIAL_RESPONDER_MACROS_SVH
`define WIFI_MODULE_SERIAL_RESPONDER_MACROS_SVH

`ifndef SYNTHESIS
`define WMSR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WMSR_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define WMSR_ASSERT(label, clk, rst, prop, msg)
`define WMSR_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

// ----- rtl/wmsr_pkg.sv -----
// Types, protocol constants and the response microprogram of the serial responder.
package wmsr_pkg;

   typedef enum logic [1:0] {
      CMD_RX_BYTE = 2'd0,
      CMD_BUTTON  = 2'd1,
      CMD_TICK    = 2'd2
   } cmd_type;

   localparam logic [7:0] FRAME_HEAD0     = 8'h55;
   localparam logic [7:0] FRAME_HEAD1     = 8'hAA;
   localparam logic [7:0] FCMD_HEARTBEAT  = 8'h00;
   localparam logic [7:0] FCMD_PRODUCT    = 8'h01;
   localparam logic [7:0] FCMD_MODE       = 8'h02;
   localparam logic [7:0] FCMD_NET        = 8'h03;
   localparam logic [7:0] FCMD_DATA_POINT = 8'h06;
   localparam logic [7:0] DP_LEVEL        = 8'h65;
   localparam logic [7:0] DP_SWITCH       = 8'h66;
   localparam logic [7:0] NET_CONNECTED   = 8'h04;
   localparam logic [7:0] LEVEL_SUM_BASE  = 8'h7C;
   localparam logic [7:0] SWITCH_SUM_BASE = 8'h76;

   localparam logic [15:0] LONG_PRESS_RESET = 16'd3000;
   localparam logic [15:0] LAMP_LEVEL_RESET = 16'd10;

   localparam int UC_PC_W  = 7;
   localparam int UC_DEPTH = 128;

   localparam logic [UC_PC_W-1:0] UC_HB_FIRST    = 7'd0;
   localparam logic [UC_PC_W-1:0] UC_HB_LATER    = 7'd8;
   localparam logic [UC_PC_W-1:0] UC_PAIRING     = 7'd16;
   localparam logic [UC_PC_W-1:0] UC_PRODUCT     = 7'd24;
   localparam logic [UC_PC_W-1:0] UC_MODE        = 7'd73;
   localparam logic [UC_PC_W-1:0] UC_NET         = 7'd80;
   localparam logic [UC_PC_W-1:0] UC_REPORT      = 7'd87;
   localparam logic [UC_PC_W-1:0] UC_LEVEL_HI    = 7'd99;
   localparam logic [UC_PC_W-1:0] UC_LEVEL_LO    = 7'd100;
   localparam logic [UC_PC_W-1:0] UC_LEVEL_SUM   = 7'd101;
   localparam logic [UC_PC_W-1:0] UC_SWITCH      = 7'd112;
   localparam logic [UC_PC_W-1:0] UC_REPORT_END  = 7'd113;

   typedef enum logic [2:0] {
      SRC_CONST,
      SRC_LEVEL_HI,
      SRC_LEVEL_LO,
      SRC_LEVEL_SUM,
      SRC_SWITCH,
      SRC_SWITCH_SUM
   } ucode_src_type;

   typedef enum logic [1:0] {
      FLOW_NEXT,
      FLOW_STOP,
      FLOW_CHAIN
   } ucode_flow_type;

   typedef struct packed {
      ucode_src_type  src;
      ucode_flow_type flow;
      logic [7:0]     data;
   } ucode_word_type;

   typedef struct packed {
      logic               valid;
      logic [UC_PC_W-1:0] entry;
      logic               chain;
   } seq_start_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   localparam logic [7:0] UCODE_BYTES [0:UC_DEPTH-1] = '{
      8'h55, 8'hAA, 8'h03, 8'h00, 8'h00, 8'h01, 8'h00, 8'h03,
      8'h55, 8'hAA, 8'h03, 8'h00, 8'h00, 8'h01, 8'h01, 8'h04,
      8'h55, 8'hAA, 8'h03, 8'h05, 8'h00, 8'h01, 8'h01, 8'h09,
      8'h55, 8'hAA, 8'h03, 8'h01, 8'h00, 8'h2A, 8'h7B, 8'h22,
      8'h70, 8'h22, 8'h3A, 8'h22, 8'h78, 8'h68, 8'h6E, 8'h7A,
      8'h74, 8'h79, 8'h64, 8'h67, 8'h77, 8'h64, 8'h63, 8'h67,
      8'h6B, 8'h71, 8'h78, 8'h64, 8'h22, 8'h2C, 8'h22, 8'h76,
      8'h22, 8'h3A, 8'h22, 8'h31, 8'h2E, 8'h30, 8'h2E, 8'h30,
      8'h22, 8'h2C, 8'h22, 8'h6D, 8'h22, 8'h3A, 8'h30, 8'h7D,
      8'hCC,
      8'h55, 8'hAA, 8'h03, 8'h02, 8'h00, 8'h00, 8'h04,
      8'h55, 8'hAA, 8'h03, 8'h03, 8'h00, 8'h00, 8'h05,
      8'h55, 8'hAA, 8'h03, 8'h07, 8'h00, 8'h08, 8'h65, 8'h02,
      8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h55, 8'hAA, 8'h03, 8'h07, 8'h00, 8'h05, 8'h66, 8'h01,
      8'h00, 8'h01, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   function automatic ucode_word_type ucode_fetch(input logic [UC_PC_W-1:0] pc);
      ucode_word_type w;
      w.data = UCODE_BYTES[pc];
      case (pc)
         UC_LEVEL_HI:   w.src = SRC_LEVEL_HI;
         UC_LEVEL_LO:   w.src = SRC_LEVEL_LO;
         UC_LEVEL_SUM:  w.src = SRC_LEVEL_SUM;
         UC_SWITCH:     w.src = SRC_SWITCH;
         UC_REPORT_END: w.src = SRC_SWITCH_SUM;
         default:       w.src = SRC_CONST;
      endcase
      case (pc) inside
         UC_HB_LATER - 7'd1, UC_PAIRING - 7'd1, UC_PRODUCT - 7'd1,
         UC_MODE - 7'd1, UC_NET - 7'd1, UC_REPORT - 7'd1:
            w.flow = FLOW_STOP;
         UC_REPORT_END:
            w.flow = FLOW_CHAIN;
         default:
            w.flow = FLOW_NEXT;
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/wmsr_sequencer.sv -----
// Microcoded response sequencer with its output register.
module wmsr_sequencer
   import wmsr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  seq_start_type start,
   input  logic          lamp_on,
   input  logic [15:0]   lamp_level,
   output logic          busy,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_tx_byte,
   output logic          rsp_last,
   output logic          rsp_led_on,
   output logic [15:0]   rsp_brightness
);

   seq_state_type      state_ff, state_in;
   logic [UC_PC_W-1:0] pc_ff, pc_in;
   logic               chain_ff, chain_in;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_byte_ff, out_byte_in;
   logic               out_last_ff, out_last_in;
   logic               out_led_ff, out_led_in;
   logic [15:0]        out_level_ff, out_level_in;

   ucode_word_type     cw;
   logic               step;
   logic [7:0]         step_byte;
   logic [7:0]         sw_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         out_valid_ff <= 1'b0;
         chain_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         chain_ff     <= chain_in;
      end
      pc_ff        <= pc_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_led_ff   <= out_led_in;
      out_level_ff <= out_level_in;
   end

   assign cw      = ucode_fetch(pc_ff);
   assign step    = (state_ff == SEQ_RUN) && (!out_valid_ff || !rsp_stall);
   assign sw_byte = {7'd0, lamp_on};

   always_comb begin
      case (cw.src)
         SRC_CONST:      step_byte = cw.data;
         SRC_LEVEL_HI:   step_byte = lamp_level[15:8];
         SRC_LEVEL_LO:   step_byte = lamp_level[7:0];
         SRC_LEVEL_SUM:  step_byte = LEVEL_SUM_BASE + lamp_level[15:8] + lamp_level[7:0];
         SRC_SWITCH:     step_byte = sw_byte;
         SRC_SWITCH_SUM: step_byte = SWITCH_SUM_BASE + sw_byte;
         default:        step_byte = cw.data;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      chain_in     = chain_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_led_in   = out_led_ff;
      out_level_in = out_level_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (out_valid_ff && !rsp_stall) begin
               out_valid_in = 1'b0;
            end
            if (start.valid) begin
               state_in = SEQ_RUN;
               pc_in    = start.entry;
               chain_in = start.chain;
            end
         end
         SEQ_RUN: begin
            if (step) begin
               out_valid_in = 1'b1;
               out_byte_in  = step_byte;
               out_led_in   = lamp_on;
               out_level_in = lamp_level;
               out_last_in  = (cw.flow == FLOW_STOP) || ((cw.flow == FLOW_CHAIN) && !chain_ff);
               case (cw.flow)
                  FLOW_STOP: state_in = SEQ_IDLE;
                  FLOW_CHAIN: begin
                     if (chain_ff) begin
                        pc_in    = UC_PAIRING;
                        chain_in = 1'b0;
                     end else begin
                        state_in = SEQ_IDLE;
                     end
                  end
                  default: pc_in = pc_ff + 7'd1;
               endcase
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   assign busy           = (state_ff == SEQ_RUN);
   assign rsp_valid      = out_valid_ff;
   assign rsp_tx_byte    = out_byte_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_led_on     = out_led_ff;
   assign rsp_brightness = out_level_ff;

endmodule

// ----- rtl/wifi_module_serial_responder.sv -----
// Top level of the serial responder: frame gathering, lamp state and dispatch.
//
// Use: the request channel carries one event per transaction: a received serial
// byte, a button toggle or a one millisecond tick with the button level. The
// response channel carries the bytes to transmit, one per transaction, with
// the lamp switch and brightness alongside and a last flag on the final byte
// that an event causes. The csr port writes the long-press tick count.
// An event that causes no bytes causes no stall. An event that causes N bytes
// (up to 49) starts the microcode sequencer, which enters its run state and
// steps the first byte into the output register; one byte follows per cycle
// while the receiver does not stall. The request channel is stalled while the
// sequencer runs; the next event can be taken once the last byte is registered.
// The rate is set by the sequencer's step condition, one byte per step.
// Reset is synchronous and takes effect at once with no clearing pass: the
// frame is emptied, the lamp is off at brightness ten and the long-press
// count returns to 3000. When the receiver stalls, the output register holds
// its byte and the sequencer waits.
module wifi_module_serial_responder
   import wmsr_pkg::*;
#(
   parameter int FRAME_DEPTH = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_button_released,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   output logic        rsp_led_on,
   output logic [15:0] rsp_brightness
);

`include "wifi_module_serial_responder_macros.svh"

   localparam int LEN_W = $clog2(FRAME_DEPTH + 1);
   localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(FRAME_DEPTH);

   logic [LEN_W-1:0] frame_length_ff, frame_length_in;
   logic [7:0]       tap1_ff, tap1_in;
   logic [7:0]       tap3_ff, tap3_in;
   logic [7:0]       tap6_ff, tap6_in;
   logic [7:0]       tap10_ff, tap10_in;
   logic [7:0]       tap12_ff, tap12_in;
   logic [7:0]       tap13_ff, tap13_in;
   logic             heartbeat_seen_ff, heartbeat_seen_in;
   logic             lamp_on_ff, lamp_on_in;
   logic [15:0]      lamp_level_ff, lamp_level_in;
   logic [16:0]      press_count_ff, press_count_in;
   logic             report_due_ff, report_due_in;
   logic [15:0]      long_press_ticks_ff;

   logic             accept;
   logic             head_ok;
   logic [LEN_W-1:0] len_next;
   logic [7:0]       t1, t3, t6, t10, t12, t13;
   logic             done;
   logic [16:0]      press_limit;
   logic             pair;
   logic             busy;
   seq_start_type    start;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff     <= '0;
         tap1_ff             <= '0;
         tap3_ff             <= '0;
         tap6_ff             <= '0;
         tap10_ff            <= '0;
         tap12_ff            <= '0;
         tap13_ff            <= '0;
         heartbeat_seen_ff   <= 1'b0;
         lamp_on_ff          <= 1'b0;
         lamp_level_ff       <= LAMP_LEVEL_RESET;
         press_count_ff      <= '0;
         report_due_ff       <= 1'b0;
         long_press_ticks_ff <= LONG_PRESS_RESET;
      end else begin
         frame_length_ff   <= frame_length_in;
         tap1_ff           <= tap1_in;
         tap3_ff           <= tap3_in;
         tap6_ff           <= tap6_in;
         tap10_ff          <= tap10_in;
         tap12_ff          <= tap12_in;
         tap13_ff          <= tap13_in;
         heartbeat_seen_ff <= heartbeat_seen_in;
         lamp_on_ff        <= lamp_on_in;
         lamp_level_ff     <= lamp_level_in;
         press_count_ff    <= press_count_in;
         report_due_ff     <= report_due_in;
         if (csr_we) begin
            long_press_ticks_ff <= csr_wdata;
         end
      end
   end

   assign accept   = req_valid && !req_stall;
   assign head_ok  = (frame_length_ff != '0) || (req_rx_byte == FRAME_HEAD0);
   assign len_next = frame_length_ff + LEN_W'(1);

   assign t1  = (frame_length_ff == LEN_W'(1))  ? req_rx_byte : tap1_ff;
   assign t3  = (frame_length_ff == LEN_W'(3))  ? req_rx_byte : tap3_ff;
   assign t6  = (frame_length_ff == LEN_W'(6))  ? req_rx_byte : tap6_ff;
   assign t10 = (frame_length_ff == LEN_W'(10)) ? req_rx_byte : tap10_ff;
   assign t12 = (frame_length_ff == LEN_W'(12)) ? req_rx_byte : tap12_ff;
   assign t13 = (frame_length_ff == LEN_W'(13)) ? req_rx_byte : tap13_ff;

   always_comb begin
      if (t3 != FCMD_DATA_POINT) begin
         done = len_next >= LEN_W'(7);
      end else begin
         done = ((t6 == DP_LEVEL) && (len_next >= LEN_W'(15)))
             || ((t6 == DP_SWITCH) && (len_next >= LEN_W'(12)));
      end
   end

   assign press_limit = {1'b0, long_press_ticks_ff};

   always_comb begin
      frame_length_in   = frame_length_ff;
      tap1_in           = tap1_ff;
      tap3_in           = tap3_ff;
      tap6_in           = tap6_ff;
      tap10_in          = tap10_ff;
      tap12_in          = tap12_ff;
      tap13_in          = tap13_ff;
      heartbeat_seen_in = heartbeat_seen_ff;
      lamp_on_in        = lamp_on_ff;
      lamp_level_in     = lamp_level_ff;
      press_count_in    = press_count_ff;
      report_due_in     = report_due_ff;
      pair              = 1'b0;
      start             = '0;
      if (accept) begin
         case (req_command)
            CMD_RX_BYTE: begin
               if (head_ok) begin
                  frame_length_in = len_next;
                  tap1_in         = t1;
                  tap3_in         = t3;
                  tap6_in         = t6;
                  tap10_in        = t10;
                  tap12_in        = t12;
                  tap13_in        = t13;
                  if (done && (t1 == FRAME_HEAD1)) begin
                     case (t3)
                        FCMD_HEARTBEAT: begin
                           start.valid       = 1'b1;
                           start.entry       = heartbeat_seen_ff ? UC_HB_LATER : UC_HB_FIRST;
                           heartbeat_seen_in = 1'b1;
                        end
                        FCMD_PRODUCT: begin
                           start.valid = 1'b1;
                           start.entry = UC_PRODUCT;
                        end
                        FCMD_MODE: begin
                           start.valid = 1'b1;
                           start.entry = UC_MODE;
                        end
                        FCMD_NET: begin
                           start.valid = 1'b1;
                           start.entry = UC_NET;
                           if (t6 == NET_CONNECTED) begin
                              report_due_in = 1'b1;
                           end
                        end
                        FCMD_DATA_POINT: begin
                           if (t6 == DP_SWITCH) begin
                              lamp_on_in    = (t10 != 8'h00);
                              report_due_in = 1'b1;
                           end else if (t6 == DP_LEVEL) begin
                              lamp_level_in = {t12, t13};
                              report_due_in = 1'b1;
                           end
                        end
                        default: ;
                     endcase
                  end
                  if (done || (len_next >= DEPTH_L)) begin
                     frame_length_in = '0;
                     tap1_in         = '0;
                     tap3_in         = '0;
                     tap6_in         = '0;
                     tap10_in        = '0;
                     tap12_in        = '0;
                     tap13_in        = '0;
                  end
               end
            end
            CMD_BUTTON: begin
               lamp_on_in    = !lamp_on_ff;
               report_due_in = 1'b1;
            end
            CMD_TICK: begin
               if (req_button_released) begin
                  press_count_in = '0;
               end else if (press_count_ff < press_limit) begin
                  press_count_in = press_count_ff + 17'd1;
               end else if (press_count_ff == press_limit) begin
                  press_count_in = press_count_ff + 17'd1;
                  pair           = 1'b1;
               end
               if (report_due_ff) begin
                  report_due_in = 1'b0;
                  start.valid   = 1'b1;
                  start.entry   = UC_REPORT;
                  start.chain   = pair;
               end else if (pair) begin
                  start.valid = 1'b1;
                  start.entry = UC_PAIRING;
               end
            end
            default: ;
         endcase
      end
   end

   wmsr_sequencer u_sequencer (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .lamp_on        (lamp_on_ff),
      .lamp_level     (lamp_level_ff),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_last       (rsp_last),
      .rsp_led_on     (rsp_led_on),
      .rsp_brightness (rsp_brightness)
   );

   assign req_stall = busy;

   `WMSR_ASSERT_NEVER(a_frame_within_store, clock, reset, frame_length_ff >= DEPTH_L, "frame length reached the store depth")
   `WMSR_ASSERT(a_response_continues, clock, reset, (rsp_valid && !rsp_stall && !rsp_last) |=> rsp_valid, "response broke off before its last byte")
   `WMSR_ASSERT(a_no_accept_mid_response, clock, reset, (req_valid && !req_stall) |-> !(rsp_valid && !rsp_last), "request taken while a response was still running")

endmodule

// ----- tb/sv/wifi_module_serial_responder_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the serial responder: frames, reports, presses and stalls.
module wifi_module_serial_responder_test;
   import wmsr_pkg::*;

   localparam int FRAME_DEPTH = 16;
   localparam int IDX_W = $clog2(FRAME_DEPTH);
   localparam int SHORT_FRAME_LEN = 7;
   localparam int SWITCH_FRAME_LEN = 12;
   localparam int LEVEL_FRAME_LEN = 15;
   localparam int MAX_REPORTED = 10;
   localparam int PHASE_EVENTS = 48;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [7:0] DP_UNKNOWN = 8'h67;

   localparam logic [63:0] HB_FIRST_FRAME = 64'h55AA_0300_0001_0003;
   localparam logic [63:0] HB_LATER_FRAME = 64'h55AA_0300_0001_0104;
   localparam logic [63:0] PAIRING_FRAME = 64'h55AA_0305_0001_0109;
   localparam logic [55:0] MODE_FRAME = 56'h55AA_0302_0000_04;
   localparam logic [55:0] NET_FRAME = 56'h55AA_0303_0000_05;
   localparam logic [95:0] LEVEL_REPORT_HEAD = 96'h55AA_0307_0008_6502_0004_0000;
   localparam logic [79:0] SWITCH_REPORT_HEAD = 80'h55AA_0307_0005_6601_0001;
   localparam logic [391:0] PRODUCT_FRAME = {
      48'h55AA_0301_002A, 48'h7B22_7022_3A22,
      128'h7868_6E7A_7479_6467_7764_6367_6B71_7864,
      56'h222C_2276_223A_22, 40'h312E_302E_30,
      48'h222C_226D_223A, 24'h307D_CC};

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        led_on;
      logic [15:0] level;
   } tx_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = 16'h0000;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_RX_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_button_released = 1'b1;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_last;
   logic        rsp_led_on;
   logic [15:0] rsp_brightness;

   logic [7:0]  frame_mem [0:FRAME_DEPTH-1];
   int unsigned frame_len;
   bit          hb_seen;
   bit          lamp_on;
   bit          report_pending;
   logic [15:0] lamp_level;
   logic [15:0] press_limit;
   logic [16:0] press_ticks;
   logic [7:0]  burst [$];
   tx_byte_type tx_expected [$];
   tx_byte_type want_byte;
   tx_byte_type seen_byte;

   int mismatches = 0;
   int bytes_checked = 0;
   int events_sent = 0;
   int rx_sent = 0;
   int ticks_sent = 0;
   int toggles_sent = 0;
   int unused_sent = 0;

   bit jitter_on = 1'b0;
   int hold_len = 0;
   int hold_serial = 0;
   int hold_taken = 0;
   int hold_left = 0;

   wifi_module_serial_responder #(.FRAME_DEPTH(FRAME_DEPTH)) u_dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_rx_byte(req_rx_byte),
      .req_button_released(req_button_released),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_last(rsp_last),
      .rsp_led_on(rsp_led_on),
      .rsp_brightness(rsp_brightness)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(255));
   endfunction

   function automatic logic any_bit();
      return 1'($urandom_range(1));
   endfunction

   function automatic void clear_frame();
      int i;
      for (i = 0; i < FRAME_DEPTH; i++) frame_mem[IDX_W'(i)] = 8'h00;
      frame_len = 0;
   endfunction

   // Frames are packed first byte uppermost; shorter frames sit in the low bits.
   function automatic void emit(input logic [391:0] frame, input int n);
      int i;
      for (i = 0; i < n; i++) burst.push_back(frame[8*(n-1-i) +: 8]);
   endfunction

   function automatic void apply_event(input logic [1:0] cmd, input logic [7:0] b,
                                       input logic rel);
      int i;
      bit done;
      logic [7:0] hi;
      logic [7:0] lo;
      tx_byte_type rec;
      burst.delete();
      case (cmd)
         CMD_RX_BYTE: begin
            frame_mem[IDX_W'(frame_len)] = b;
            frame_len++;
            if (frame_mem[0] != FRAME_HEAD0) frame_len--;
            if (frame_mem[3] != FCMD_DATA_POINT) done = frame_len >= SHORT_FRAME_LEN;
            else if (frame_mem[6] == DP_LEVEL) done = frame_len >= LEVEL_FRAME_LEN;
            else if (frame_mem[6] == DP_SWITCH) done = frame_len >= SWITCH_FRAME_LEN;
            else done = 1'b0;
            if (done) begin
               if (frame_mem[0] == FRAME_HEAD0 && frame_mem[1] == FRAME_HEAD1) begin
                  case (frame_mem[3])
                     FCMD_HEARTBEAT: begin
                        emit(hb_seen ? HB_LATER_FRAME : HB_FIRST_FRAME, 8);
                        hb_seen = 1'b1;
                     end
                     FCMD_PRODUCT: emit(PRODUCT_FRAME, 49);
                     FCMD_MODE: emit(MODE_FRAME, 7);
                     FCMD_NET: begin
                        emit(NET_FRAME, 7);
                        if (frame_mem[6] == NET_CONNECTED) report_pending = 1'b1;
                     end
                     FCMD_DATA_POINT: begin
                        if (frame_mem[6] == DP_SWITCH) begin
                           lamp_on = frame_mem[10] != 8'h00;
                           report_pending = 1'b1;
                        end else if (frame_mem[6] == DP_LEVEL) begin
                           lamp_level = {frame_mem[12], frame_mem[13]};
                           report_pending = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
               clear_frame();
            end else if (frame_len >= FRAME_DEPTH) begin
               clear_frame();
            end
         end
         CMD_BUTTON: begin
            lamp_on = !lamp_on;
            report_pending = 1'b1;
         end
         CMD_TICK: begin
            if (report_pending) begin
               report_pending = 1'b0;
               hi = lamp_level[15:8];
               lo = lamp_level[7:0];
               emit({LEVEL_REPORT_HEAD, hi, lo, LEVEL_SUM_BASE + hi + lo}, 15);
               emit({SWITCH_REPORT_HEAD, 7'd0, lamp_on, SWITCH_SUM_BASE + {7'd0, lamp_on}}, 12);
            end
            if (rel) begin
               press_ticks = '0;
            end else if (press_ticks < press_limit) begin
               press_ticks++;
            end else if (press_ticks == press_limit) begin
               press_ticks++;
               emit(PAIRING_FRAME, 8);
            end
         end
         default: ;
      endcase
      for (i = 0; i < burst.size(); i++) begin
         rec.data = burst[i];
         rec.last = (i == burst.size() - 1);
         rec.led_on = lamp_on;
         rec.level = lamp_level;
         tx_expected.push_back(rec);
      end
   endfunction

   task automatic send_event(input logic [1:0] cmd, input logic [7:0] b, input logic rel);
      if (jitter_on && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_rx_byte <= b;
      req_button_released <= rel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_event(cmd, b, rel);
      events_sent++;
      case (cmd)
         CMD_RX_BYTE: rx_sent++;
         CMD_BUTTON: toggles_sent++;
         CMD_TICK: ticks_sent++;
         default: unused_sent++;
      endcase
   endtask

   // Byte 6 carries the data point or network status; the value lands where that point keeps it.
   task automatic send_frame(input logic [7:0] fcmd, input logic [7:0] dp,
                             input logic [15:0] value, input int n, input bit good_head);
      int i;
      logic [7:0] b;
      for (i = 0; i < n; i++) begin
         b = any_byte();
         case (i)
            0: b = FRAME_HEAD0;
            1: if (good_head) b = FRAME_HEAD1; else if (b == FRAME_HEAD1) b = 8'h00;
            3: b = fcmd;
            6: b = dp;
            10: if (fcmd == FCMD_DATA_POINT && dp == DP_SWITCH) b = value[7:0];
            12: if (fcmd == FCMD_DATA_POINT && dp == DP_LEVEL) b = value[15:8];
            13: if (fcmd == FCMD_DATA_POINT && dp == DP_LEVEL) b = value[7:0];
            default: ;
         endcase
         send_event(CMD_RX_BYTE, b, any_bit());
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tx_expected.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_press_limit(input logic [15:0] ticks);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= ticks;
      @(posedge clock);
      csr_we <= 1'b0;
      press_limit = ticks;
   endtask

   task automatic test_reset_reports();
      send_event(CMD_BUTTON, any_byte(), any_bit());
      send_event(CMD_TICK, any_byte(), 1'b1);
      send_event(CMD_TICK, any_byte(), 1'b1);
      send_event(CMD_UNUSED, 8'hFF, 1'b0);
      send_event(CMD_UNUSED, 8'h00, 1'b1);
      send_event(CMD_BUTTON, any_byte(), any_bit());
      send_event(CMD_TICK, any_byte(), 1'b1);
   endtask

   // A press well short of the reset limit must not send the pairing frame.
   task automatic test_default_long_press();
      repeat (20) send_event(CMD_TICK, any_byte(), 1'b0);
      send_event(CMD_TICK, any_byte(), 1'b1);
   endtask

   task automatic test_frame_answers();
      send_frame(FCMD_HEARTBEAT, any_byte(), 16'h0000, SHORT_FRAME_LEN, 1'b1);
      send_frame(FCMD_HEARTBEAT, any_byte(), 16'h0000, SHORT_FRAME_LEN, 1'b1);
      send_frame(FCMD_PRODUCT, any_byte(), 16'h0000, SHORT_FRAME_LEN, 1'b1);
      send_frame(FCMD_MODE, any_byte(), 16'h0000, SHORT_FRAME_LEN, 1'b1);
      send_frame(FCMD_NET, 8'h02, 16'h0000, SHORT_FRAME_LEN, 1'b1);
      send_event(CMD_TICK, any_byte(), 1'b1);
      send_frame(FCMD_NET, NET_CONNECTED, 16'h0000, SHORT_FRAME_LEN, 1'b1);
      send_event(CMD_TICK, any_byte(), 1'b1);
      send_frame(8'hFF, any_byte(), 16'h0000, SHORT_FRAME_LEN, 1'b1);
      send_frame(FCMD_HEARTBEAT, any_byte(), 16'h0000, SHORT_FRAME_LEN, 1'b0);
      send_event(CMD_RX_BYTE, 8'hFF, 1'b0);
      send_event(CMD_RX_BYTE, 8'hAA, 1'b1);
      send_frame(FCMD_MODE, any_byte(), 16'h0000, SHORT_FRAME_LEN, 1'b1);
   endtask

   task automatic test_lamp_data_points();
      send_frame(FCMD_DATA_POINT, DP_SWITCH, 16'h00FF, SWITCH_FRAME_LEN, 1'b1);
      send_event(CMD_TICK, any_byte(), 1'b1);
      send_frame(FCMD_DATA_POINT, DP_SWITCH, 16'h0000, SWITCH_FRAME_LEN, 1'b1);
      send_event(CMD_TICK, any_byte(), 1'b1);
      send_frame(FCMD_DATA_POINT, DP_LEVEL, 16'hFFFF, LEVEL_FRAME_LEN, 1'b1);
      send_event(CMD_TICK, any_byte(), 1'b1);
      send_frame(FCMD_DATA_POINT, DP_LEVEL, 16'h0000, LEVEL_FRAME_LEN, 1'b1);
      send_event(CMD_TICK, any_byte(), 1'b1);
      // An unknown data point never completes, so the full store is thrown away.
      send_frame(FCMD_DATA_POINT, DP_UNKNOWN, 16'h1234, FRAME_DEPTH, 1'b1);
      send_event(CMD_TICK, any_byte(), 1'b1);
      send_frame(FCMD_HEARTBEAT, any_byte(), 16'h0000, SHORT_FRAME_LEN, 1'b1);
   endtask

   task automatic test_press_limit_extremes();
      write_press_limit(16'd1);
      repeat (4) send_event(CMD_TICK, any_byte(), 1'b0);
      send_event(CMD_TICK, any_byte(), 1'b1);
      write_press_limit(16'hFFFF);
      repeat (16) send_event(CMD_TICK, any_byte(), 1'b0);
      send_event(CMD_TICK, any_byte(), 1'b1);
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_len = 300;
      hold_serial <= hold_serial + 1;
      repeat (3) send_frame(FCMD_PRODUCT, any_byte(), 16'h0000, SHORT_FRAME_LEN, 1'b1);
      send_event(CMD_BUTTON, any_byte(), 1'b1);
      send_event(CMD_TICK, any_byte(), 1'b1);
      wait_idle();
      send_frame(FCMD_NET, NET_CONNECTED, 16'h0000, SHORT_FRAME_LEN, 1'b1);
      send_event(CMD_TICK, any_byte(), 1'b1);
   endtask

   task automatic test_random_traffic();
      int phase;
      int start;
      int kind;
      int run;
      int cap;
      for (phase = 0; phase < 4; phase++) begin
         write_press_limit((phase == 3) ? LONG_PRESS_RESET : 16'($urandom_range(6, 1)));
         start = events_sent;
         while (events_sent - start < PHASE_EVENTS) begin
            jitter_on <= !(phase == 1 && events_sent - start >= 5 && events_sent - start < 43);
            kind = $urandom_range(99);
            if (kind < 55) begin
               case ($urandom_range(6))
                  0: send_frame(FCMD_HEARTBEAT, any_byte(), 16'h0000,
                                SHORT_FRAME_LEN, 1'b1);
                  1: send_frame(FCMD_PRODUCT, any_byte(), 16'h0000,
                                SHORT_FRAME_LEN, 1'b1);
                  2: send_frame(FCMD_MODE, any_byte(), 16'h0000,
                                SHORT_FRAME_LEN, 1'b1);
                  3: send_frame(FCMD_NET, any_bit() ? NET_CONNECTED : any_byte(),
                                16'h0000, SHORT_FRAME_LEN, 1'b1);
                  4: send_frame(FCMD_DATA_POINT, DP_SWITCH,
                                any_bit() ? 16'h0000 : 16'($urandom_range(65535)),
                                SWITCH_FRAME_LEN, 1'b1);
                  5: send_frame(FCMD_DATA_POINT, DP_LEVEL, 16'($urandom_range(65535)),
                                LEVEL_FRAME_LEN, 1'b1);
                  default: send_frame(8'($urandom_range(255, 7)), any_byte(), 16'h0000,
                                      SHORT_FRAME_LEN, 1'b1);
               endcase
            end else if (kind < 73) begin
               if ($urandom_range(2) == 0) begin
                  cap = (press_limit > 8) ? 8 : int'(press_limit) + 2;
                  run = $urandom_range(cap, 1);
                  repeat (run) send_event(CMD_TICK, any_byte(), 1'b0);
               end
               send_event(CMD_TICK, any_byte(), 1'b1);
            end else if (kind < 81) begin
               send_event(CMD_BUTTON, any_byte(), any_bit());
            end else begin
               case ($urandom_range(3))
                  0: repeat ($urandom_range(3, 1))
                        send_event(CMD_RX_BYTE, any_byte(), any_bit());
                  1: send_frame(FCMD_HEARTBEAT, any_byte(), 16'h0000,
                                SHORT_FRAME_LEN, 1'b0);
                  2: send_frame(FCMD_DATA_POINT, DP_UNKNOWN, 16'($urandom_range(65535)),
                                FRAME_DEPTH, 1'b1);
                  default: send_frame(FCMD_DATA_POINT, any_bit() ? DP_LEVEL : DP_SWITCH,
                                      16'($urandom_range(65535)), $urandom_range(6, 2), 1'b1);
               endcase
            end
         end
      end
      jitter_on <= 1'b1;
   endtask

   always @(posedge clock) begin
      if (hold_serial != hold_taken) begin
         hold_taken <= hold_serial;
         hold_left <= hold_len;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= jitter_on && ($urandom_range(99) < 16);
      end
   end

   function automatic void note_mismatch(input string what, input tx_byte_type want,
                                         input tx_byte_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTED) begin
         $write("%0t %s: expected byte %02h last %0b led %0b level %0d, ", $realtime, what,
                want.data, want.last, want.led_on, want.level);
         $display("got byte %02h last %0b led %0b level %0d",
                  got.data, got.last, got.led_on, got.level);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_byte = {rsp_tx_byte, rsp_last, rsp_led_on, rsp_brightness};
         if (tx_expected.size() == 0) begin
            note_mismatch("unexpected transaction", '0, seen_byte);
         end else begin
            want_byte = tx_expected.pop_front();
            if (want_byte !== seen_byte) note_mismatch("transaction mismatch", want_byte, seen_byte);
            bytes_checked++;
         end
      end
   end

   initial begin
      clear_frame();
      hb_seen = 1'b0;
      lamp_on = 1'b0;
      report_pending = 1'b0;
      lamp_level = LAMP_LEVEL_RESET;
      press_limit = LONG_PRESS_RESET;
      press_ticks = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      jitter_on <= 1'b1;
      test_reset_reports();
      test_default_long_press();
      test_frame_answers();
      test_lamp_data_points();
      test_press_limit_extremes();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      repeat (20) @(posedge clock);
      mismatches += tx_expected.size();
      $display("Sent %0d events: %0d serial bytes, %0d ticks, %0d button toggles,",
               events_sent, rx_sent, ticks_sent, toggles_sent);
      $display("%0d unused codes; checked %0d transmitted bytes over several press limits, %0d failures.",
               unused_sent, bytes_checked, mismatches);
      if (mismatches == 0) begin
         $display("wifi_module_serial_responder verification clean");
      end else begin
         $display("wifi_module_serial_responder verification failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("wifi_module_serial_responder verification failed");
      $finish;
   end

endmodule
